/* src/pkhp_pkg.sv */
// ----------------------------------------------------------------------------
// pkhp_pkg
// Types and constants shared by the packet header length parser modules.
// ----------------------------------------------------------------------------
package pkhp_pkg;

  localparam logic [2:0] MaxTags = 3'd4;

  localparam logic [15:0] EtypeVlan  = 16'h8100;
  localparam logic [15:0] EtypeQinq  = 16'h88a8;
  localparam logic [15:0] EtypeIpv4  = 16'h0800;
  localparam logic [15:0] EtypeIpv6  = 16'h86dd;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam logic [7:0]  LowNibble  = 8'h0f;
  localparam logic [7:0]  HighNibble = 8'hf0;

  localparam logic [7:0] EtypeOffset  = 8'd12;
  localparam logic [7:0] Ipv4ProtoOff = 8'd9;
  localparam logic [7:0] Ipv6ProtoOff = 8'd6;
  localparam logic [7:0] TcpOffOff    = 8'd12;
  localparam logic [5:0] Ipv6HdrLen   = 6'd40;
  localparam logic [5:0] UdpHdrLen    = 6'd8;
  localparam logic [5:0] EthHdrLen    = 6'd14;
  localparam logic [3:0] MinIhl       = 4'd5;

  localparam int unsigned OutDataW = 24;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StNotIp   = 3'd1,
    StNotL4   = 3'd2,
    StTrunc   = 3'd3,
    StTags    = 3'd4,
    StBadIhl  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PhEth  = 4'b0001,
    PhL3   = 4'b0010,
    PhL4   = 4'b0100,
    PhDone = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [5:0] l4_length;
    logic [5:0] l3_length;
    logic [4:0] l2_length;
    status_e    status;
  } result_t;

endpackage

/* src/pkhp_parse.sv */
// ----------------------------------------------------------------------------
// pkhp_parse
// Per-frame parse state; updates on each stepped byte and forms the result
// on the last byte, then returns to the start-of-frame state.
// ----------------------------------------------------------------------------
module pkhp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output pkhp_pkg::result_t result_o
);

  pkhp_pkg::phase_e  phase_q, phase_d, phase_u;
  pkhp_pkg::status_e status_q, status_d, status_u;
  logic [7:0] pos_q, pos_d, pos_u;
  logic [7:0] held_q, held_d, held_u;
  logic [2:0] tags_q, tags_d, tags_u;
  logic [5:0] l3_q, l3_d, l3_u;
  logic [5:0] l4_q, l4_d, l4_u;
  logic       ipv6_q, ipv6_d, ipv6_u;
  logic       l2k_q, l2k_d, l2k_u;

  logic [7:0]  et_pos;
  logic [7:0]  l3_pos;
  logic [7:0]  proto_pos;
  logic [7:0]  tcp_pos;
  logic [15:0] etype;
  logic [5:0]  l2_sum;

  assign et_pos    = pkhp_pkg::EtypeOffset + {3'b000, tags_q, 2'b00};
  assign l3_pos    = et_pos + 8'd2;
  assign proto_pos = l3_pos + (ipv6_q ? pkhp_pkg::Ipv6ProtoOff : pkhp_pkg::Ipv4ProtoOff);
  assign tcp_pos   = l3_pos + {2'b00, l3_q} + pkhp_pkg::TcpOffOff;
  assign etype     = {held_q, byte_i};

  always_comb begin
    phase_u  = phase_q;
    status_u = status_q;
    held_u   = held_q;
    tags_u   = tags_q;
    l3_u     = l3_q;
    l4_u     = l4_q;
    ipv6_u   = ipv6_q;
    l2k_u    = l2k_q;
    pos_u    = (pos_q == 8'hff) ? pos_q : pos_q + 8'd1;
    case (phase_q)
      pkhp_pkg::PhEth: begin
        if (pos_q == et_pos) begin
          held_u = byte_i;
        end else if (pos_q == et_pos + 8'd1) begin
          if (etype == pkhp_pkg::EtypeVlan || etype == pkhp_pkg::EtypeQinq) begin
            if (tags_q >= pkhp_pkg::MaxTags) begin
              status_u = pkhp_pkg::StTags;
              phase_u  = pkhp_pkg::PhDone;
            end else begin
              tags_u = tags_q + 3'd1;
            end
          end else begin
            l2k_u = 1'b1;
            if (etype == pkhp_pkg::EtypeIpv4) begin
              ipv6_u  = 1'b0;
              phase_u = pkhp_pkg::PhL3;
            end else if (etype == pkhp_pkg::EtypeIpv6) begin
              ipv6_u  = 1'b1;
              phase_u = pkhp_pkg::PhL3;
            end else begin
              status_u = pkhp_pkg::StNotIp;
              phase_u  = pkhp_pkg::PhDone;
            end
          end
        end
      end
      pkhp_pkg::PhL3: begin
        if (pos_q == l3_pos) begin
          if (ipv6_q) begin
            l3_u = pkhp_pkg::Ipv6HdrLen;
          end else begin
            l3_u = {byte_i[3:0], 2'b00};
            if ((byte_i & pkhp_pkg::LowNibble) < {4'h0, pkhp_pkg::MinIhl}) begin
              status_u = pkhp_pkg::StBadIhl;
              phase_u  = pkhp_pkg::PhDone;
            end
          end
        end else if (pos_q == proto_pos) begin
          if (byte_i == pkhp_pkg::ProtoTcp) begin
            phase_u = pkhp_pkg::PhL4;
          end else if (byte_i == pkhp_pkg::ProtoUdp) begin
            l4_u     = pkhp_pkg::UdpHdrLen;
            status_u = pkhp_pkg::StOk;
            phase_u  = pkhp_pkg::PhDone;
          end else begin
            status_u = pkhp_pkg::StNotL4;
            phase_u  = pkhp_pkg::PhDone;
          end
        end
      end
      pkhp_pkg::PhL4: begin
        if (pos_q == tcp_pos) begin
          l4_u     = {byte_i[7:4], 2'b00};
          status_u = pkhp_pkg::StOk;
          phase_u  = pkhp_pkg::PhDone;
        end
      end
      default: begin
      end
    endcase
  end

  assign l2_sum = pkhp_pkg::EthHdrLen + {1'b0, tags_u, 2'b00};

  always_comb begin
    result_o.status    = status_u;
    result_o.l2_length = l2k_u ? l2_sum[4:0] : 5'd0;
    result_o.l3_length = l3_u;
    result_o.l4_length = l4_u;
    if (status_u == pkhp_pkg::StTags) begin
      result_o.l2_length = 5'd0;
      result_o.l3_length = 6'd0;
      result_o.l4_length = 6'd0;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    pos_d    = pos_q;
    held_d   = held_q;
    tags_d   = tags_q;
    l3_d     = l3_q;
    l4_d     = l4_q;
    ipv6_d   = ipv6_q;
    l2k_d    = l2k_q;
    if (step_i && last_i) begin
      phase_d  = pkhp_pkg::PhEth;
      status_d = pkhp_pkg::StTrunc;
      pos_d    = 8'd0;
      held_d   = 8'd0;
      tags_d   = 3'd0;
      l3_d     = 6'd0;
      l4_d     = 6'd0;
      ipv6_d   = 1'b0;
      l2k_d    = 1'b0;
    end else if (step_i) begin
      phase_d  = phase_u;
      status_d = status_u;
      pos_d    = pos_u;
      held_d   = held_u;
      tags_d   = tags_u;
      l3_d     = l3_u;
      l4_d     = l4_u;
      ipv6_d   = ipv6_u;
      l2k_d    = l2k_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pkhp_pkg::PhEth;
      status_q <= pkhp_pkg::StTrunc;
      pos_q    <= 8'd0;
      held_q   <= 8'd0;
      tags_q   <= 3'd0;
      l3_q     <= 6'd0;
      l4_q     <= 6'd0;
      ipv6_q   <= 1'b0;
      l2k_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      status_q <= status_d;
      pos_q    <= pos_d;
      held_q   <= held_d;
      tags_q   <= tags_d;
      l3_q     <= l3_d;
      l4_q     <= l4_d;
      ipv6_q   <= ipv6_d;
      l2k_q    <= l2k_d;
    end
  end

endmodule

/* src/pkhp_out_reg.sv */
// ----------------------------------------------------------------------------
// pkhp_out_reg
// Result register on the master side; holds a word until it is taken.
// ----------------------------------------------------------------------------
module pkhp_out_reg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  pkhp_pkg::result_t               result_i,
  output logic                            space_o,
  output logic                            tvalid_o,
  input  logic                            tready_i,
  output logic [pkhp_pkg::OutDataW-1:0]   tdata_o
);

  logic              valid_q, valid_d;
  pkhp_pkg::result_t data_q;

  assign space_o = !valid_q || tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = {{(pkhp_pkg::OutDataW - $bits(pkhp_pkg::result_t)){1'b0}}, data_q};

endmodule

/* src/packet_header_length_parser.sv */
// ----------------------------------------------------------------------------
// packet_header_length_parser
// Parses an Ethernet frame one byte per word and reports the L2, L3 and L4
// header lengths with a status word on the frame's last byte.
//
//   port     dir  tdata bits (low first)                     tlast
//   s_axis   in   pkt_byte[7:0]                               is_last
//   m_axis   out  status[2:0] l2[7:3] l3[13:8] l4[19:14] pad  -
//
// one byte per cycle unless a last byte waits for m_axis space; a byte is held in
// the input register while the parse logic works on it, and the result of a last
// byte is loaded from there into the m_axis register once that register has space
// reset returns the parser to the start of a frame and empties both registers
// a stalled m_axis holds only the last byte of a frame; other bytes keep going
// ----------------------------------------------------------------------------
module packet_header_length_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // pkt_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // status, l2_length, l3_length, l4_length
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_space;
  logic       advance;
  logic       s_fire;

  pkhp_pkg::result_t result;

  assign advance         = in_valid_q && (!in_last_q || out_space);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  pkhp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (result)
  );

  pkhp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && in_last_q),
    .result_i (result),
    .space_o  (out_space),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .tdata_o  (m_axis_tdata_o)
  );

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input register empty but not ready");

  a_tags_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] == pkhp_pkg::StTags
    |-> m_axis_tdata_o[19:3] == 17'd0)
    else $error("tag overflow result carries lengths");

  a_ok_lengths : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2:0] == pkhp_pkg::StOk
    |-> m_axis_tdata_o[7:3] != 5'd0 && m_axis_tdata_o[13:8] != 6'd0)
    else $error("ok result without l2 or l3 length");

  a_nonlast_passes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_last_q |-> advance)
    else $error("non-last byte stalled");

endmodule
